// ===== rtl/fsba_pkg.sv =====
package fsba_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h7D;
  localparam logic [7:0] HDR_SECOND = 8'h5D;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 24;
  localparam int COUNT_W  = 8;
  localparam int ANGLE_W  = 25;
  localparam int PROD_W   = 34;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREES_PER_COUNT = 2'd2;

  localparam logic [COUNT_W-1:0]  WINDOW_RESET = 8'd50;
  localparam logic [SAMPLE_W-1:0] ZERO_RESET   = 16'd3532;
  localparam logic [SAMPLE_W-1:0] SCALE_RESET  = 16'd4048;

  localparam logic [PROD_W-1:0] ROUND_HALF = 34'd128;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HDR1,
    PH_HDR2,
    PH_HIGH
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_MUL,
    SEQ_OUT
  } seq_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/fsba_div.sv =====
module fsba_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [fsba_pkg::TOTAL_W-1:0]      dividend,
  input  logic [fsba_pkg::COUNT_W-1:0]      divisor,
  output logic [fsba_pkg::TOTAL_W-1:0]      quotient,
  output fsba_pkg::div_status_t             status
);

  localparam int CNT_W = $clog2(fsba_pkg::TOTAL_W + 1);

  logic [fsba_pkg::TOTAL_W-1:0] dvd_r, dvd_nxt;
  logic [fsba_pkg::COUNT_W-1:0] rem_r, rem_nxt;
  logic [fsba_pkg::COUNT_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [fsba_pkg::COUNT_W:0]   trial;
  logic                         fits;

  // one quotient bit per cycle, shifted into the dividend register
  assign trial = {rem_r, dvd_r[fsba_pkg::TOTAL_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(fsba_pkg::TOTAL_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[fsba_pkg::TOTAL_W-2:0], fits};
      rem_nxt = fits ? fsba_pkg::COUNT_W'(trial - {1'b0, dsr_r})
                     : trial[fsba_pkg::COUNT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient    = dvd_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== rtl/framed_sample_block_averager.sv =====
// Header and first sample bytes are taken one per cycle while in_tready is high.
// The byte that closes a window starts a restoring divide (one quotient bit per cycle
// in the divider), then a scale multiply; out_tvalid rises when the result is loaded
// into the output register, once any earlier result is taken. in_tready is low until then.
// Synchronous active-low reset: framing idle, sum and count cleared, registers to
// window 50, offset 3532, scale 4048; no result pending.
module framed_sample_block_averager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [15:0] mean_raw, [40:16] tilt_angle, [47:41] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SW = fsba_pkg::SAMPLE_W;
  localparam int TW = fsba_pkg::TOTAL_W;
  localparam int CW = fsba_pkg::COUNT_W;
  localparam int AW = fsba_pkg::ANGLE_W;
  localparam int PW = fsba_pkg::PROD_W;

  logic [CW-1:0] window_r;
  logic [SW-1:0] zero_r;
  logic [SW-1:0] scale_r;

  fsba_pkg::phase_t phase_r, phase_nxt;
  fsba_pkg::seq_t   seq_r, seq_nxt;

  logic [7:0]    high_r, high_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [CW-1:0] taken_r, taken_nxt;

  logic [SW-1:0] mean_r, mean_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          out_valid_r;
  logic [SW-1:0] out_mean_r;
  logic [AW-1:0] out_angle_r;

  logic                  in_acc;
  logic                  sample_done;
  logic                  div_start;
  logic                  load_out;
  logic [TW-1:0]         quotient;
  fsba_pkg::div_status_t div_stat;
  logic [SW:0]           diff;
  logic [PW-1:0]         rounded;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= fsba_pkg::WINDOW_RESET;
      zero_r   <= fsba_pkg::ZERO_RESET;
      scale_r  <= fsba_pkg::SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fsba_pkg::REG_WINDOW_LENGTH:     window_r <= cfg_data[CW-1:0];
        fsba_pkg::REG_ZERO_OFFSET:       zero_r   <= cfg_data;
        fsba_pkg::REG_DEGREES_PER_COUNT: scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // framing
  assign in_acc      = in_tvalid && in_tready;
  assign sample_done = in_acc && (phase_r == fsba_pkg::PH_HIGH);

  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      unique case (phase_r)
        fsba_pkg::PH_IDLE:
          if (in_tdata == fsba_pkg::HDR_FIRST) phase_nxt = fsba_pkg::PH_HDR1;
        fsba_pkg::PH_HDR1:
          phase_nxt = (in_tdata == fsba_pkg::HDR_SECOND) ? fsba_pkg::PH_HDR2
                                                         : fsba_pkg::PH_IDLE;
        fsba_pkg::PH_HDR2: phase_nxt = fsba_pkg::PH_HIGH;
        fsba_pkg::PH_HIGH: phase_nxt = fsba_pkg::PH_IDLE;
        default:           phase_nxt = fsba_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    high_nxt  = high_r;
    total_nxt = total_r;
    taken_nxt = taken_r;
    if (in_acc && phase_r == fsba_pkg::PH_HDR2) begin
      high_nxt = in_tdata;
    end
    if (sample_done) begin
      if (taken_r < window_r) begin
        total_nxt = total_r + TW'({high_r, in_tdata});
        taken_nxt = taken_r + 1'b1;
      end else begin
        total_nxt = '0;
        taken_nxt = '0;
      end
    end
  end

  // sequencer
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      fsba_pkg::SEQ_IDLE: if (div_start)       seq_nxt = fsba_pkg::SEQ_DIV;
      fsba_pkg::SEQ_DIV:  if (div_stat.done)   seq_nxt = fsba_pkg::SEQ_MUL;
      fsba_pkg::SEQ_MUL:                       seq_nxt = fsba_pkg::SEQ_OUT;
      fsba_pkg::SEQ_OUT:  if (load_out)        seq_nxt = fsba_pkg::SEQ_IDLE;
      default:                                 seq_nxt = fsba_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (seq_r == fsba_pkg::SEQ_IDLE);
    div_start = sample_done && !(taken_r < window_r);
    load_out  = (seq_r == fsba_pkg::SEQ_OUT) && (!out_valid_r || out_tready);
  end

  fsba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  ((window_r == '0) ? CW'(1) : window_r),
    .quotient (quotient),
    .status   (div_stat)
  );

  // saturate the mean, then scale its distance from the zero point
  always_comb begin
    mean_nxt = mean_r;
    prod_nxt = prod_r;
    diff     = {1'b0, mean_r} - {1'b0, zero_r};
    if (seq_r == fsba_pkg::SEQ_MUL) begin
      mean_nxt = (|quotient[TW-1:SW]) ? {SW{1'b1}} : quotient[SW-1:0];
      diff     = {1'b0, mean_nxt} - {1'b0, zero_r};
      prod_nxt = PW'($signed(diff) * $signed({1'b0, scale_r}));
    end
  end

  assign rounded = PW'($signed(prod_r + fsba_pkg::ROUND_HALF) >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fsba_pkg::PH_IDLE;
      seq_r       <= fsba_pkg::SEQ_IDLE;
      high_r      <= '0;
      total_r     <= '0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      high_r  <= high_nxt;
      total_r <= total_nxt;
      taken_r <= taken_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    mean_r <= mean_nxt;
    prod_r <= prod_nxt;
    if (load_out) begin
      out_mean_r  <= mean_r;
      out_angle_r <= rounded[AW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_angle_r, out_mean_r};

endmodule
